// ----- sv/ffea_pkg.sv -----
// shared types and constants for the first-fit extent allocator
package ffea_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] request_address;
        logic [31:0] request_size;
    } req_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic [2:0]  status;
        logic [31:0] free_bytes;
    } rsp_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } entry_t;

    localparam logic [1:0] KIND_FIRST   = 2'd0;
    localparam logic [1:0] KIND_HIGHEST = 2'd1;
    localparam logic [1:0] KIND_AT      = 2'd2;
    localparam logic [1:0] KIND_FREE    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_REM  = 2'd1;
    localparam logic [1:0] OP_INS  = 2'd2;

    localparam logic [2:0] REG_HEAP_BASE = 3'd0;
    localparam logic [2:0] REG_HEAP_SIZE = 3'd4;

endpackage

// ----- sv/ffea_ext_mem.sv -----
// extent table memory, one write port and one registered read port
module ffea_ext_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  ffea_pkg::entry_t      wdata,
    input  logic [AW-1:0]         raddr,
    output ffea_pkg::entry_t      rdata
);
    import ffea_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/first_fit_extent_allocator_core.sv -----
// first-fit extent allocator: request sequencer over the extent table memory
//
//  port group      dir   transaction
//  start/req       in    accepted when start is high, busy low and no apb write
//  done/rsp        out   one result per request, valid for one cycle at done
//  apb p*          in    heap_base at 0, heap_size at 4; idle write resets the table
//
//  a request scans the extents one per cycle through the memory read port, and
//  an insert or remove then shifts the entries that follow the changed extent
//  reset empties the table; heap_base and heap_size read as zero
//  busy stays high from acceptance until the cycle before done
//  the receiver cannot stall; done is a single-cycle strobe
module first_fit_extent_allocator_core #(
    parameter int MAX_EXTENTS = 32,
    parameter int ADDR_BITS   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffea_pkg::req_t req,
    output logic           done,
    output ffea_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import ffea_pkg::*;

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int AL = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam logic [33:0] ADDR_LIMIT = 34'(1) << AL;
    localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_SHIFT  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   base_reg, base_next, hsize_reg, hsize_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   free_reg, free_next;

    logic [1:0]    kind_reg, kind_next;
    logic [31:0]   a_reg, a_next, size_reg, size_next;
    logic [32:0]   rsize_reg, rsize_next;
    logic [33:0]   ar_reg, ar_next;

    logic [CW-1:0] iss_reg, iss_next;
    logic          dv_reg, dv_next;
    logic [IW-1:0] didx_reg, didx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] pick_reg, pick_next;
    entry_t        pe_reg, pe_next;
    logic          prv_reg, prv_next, nxv_reg, nxv_next;
    entry_t        prev_reg, prev_next, nxt_reg, nxt_next;
    logic [CW-1:0] fidx_reg, fidx_next;

    logic [2:0]    st_reg, st_next;
    logic [31:0]   addr_reg, addr_next;
    logic          wen_reg, wen_next;
    logic [IW-1:0] widx_reg, widx_next;
    entry_t        wd_reg, wd_next;
    logic [1:0]    op_reg, op_next;
    logic [CW-1:0] opi_reg, opi_next;
    entry_t        ins_reg, ins_next;
    logic [31:0]   nfree_reg, nfree_next;

    logic [CW-1:0] sh_reg, sh_next;
    logic          shv_reg, shv_next;
    logic [IW-1:0] shwa_reg, shwa_next;

    logic          done_reg, done_next;
    rsp_t          rsp_reg, rsp_next;

    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    entry_t        mem_wd, rd;

    logic          cfg_wr;
    logic [33:0]   room, clen;
    logic          issue, hit, stop;
    logic [32:0]   e_end, ptop;
    logic          head, tail, ign, mprev, mnext;
    logic [31:0]   len1;
    logic [32:0]   rsz;

    ffea_ext_mem #(
        .DEPTH (MAX_EXTENTS),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .raddr (mem_ra),
        .rdata (rd)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    always_comb
    begin
        unique case (paddr)
            REG_HEAP_BASE: prdata = base_reg;
            REG_HEAP_SIZE: prdata = hsize_reg;
            default:       prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        hsize_next = hsize_reg;
        count_next = count_reg;
        free_next  = free_reg;
        kind_next  = kind_reg;
        a_next     = a_reg;
        size_next  = size_reg;
        rsize_next = rsize_reg;
        ar_next    = ar_reg;
        iss_next   = iss_reg;
        dv_next    = 1'b0;
        didx_next  = didx_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        pe_next    = pe_reg;
        prv_next   = prv_reg;
        nxv_next   = nxv_reg;
        prev_next  = prev_reg;
        nxt_next   = nxt_reg;
        fidx_next  = fidx_reg;
        st_next    = st_reg;
        addr_next  = addr_reg;
        wen_next   = wen_reg;
        widx_next  = widx_reg;
        wd_next    = wd_reg;
        op_next    = op_reg;
        opi_next   = opi_reg;
        ins_next   = ins_reg;
        nfree_next = nfree_reg;
        sh_next    = sh_reg;
        shv_next   = 1'b0;
        shwa_next  = shwa_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = wd_reg;
        mem_ra     = iss_reg[IW-1:0];
        room       = '0;
        clen       = '0;
        issue      = 1'b0;
        hit        = 1'b0;
        stop       = 1'b0;
        e_end      = '0;
        ptop       = '0;
        head       = 1'b0;
        tail       = 1'b0;
        ign        = 1'b0;
        mprev      = 1'b0;
        mnext      = 1'b0;
        len1       = '0;
        rsz        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr)
                begin
                    if (paddr == REG_HEAP_BASE)
                    begin
                        base_next = pwdata;
                    end
                    else if (paddr == REG_HEAP_SIZE)
                    begin
                        hsize_next = pwdata;
                    end
                    if (paddr == REG_HEAP_BASE || paddr == REG_HEAP_SIZE)
                    begin
                        count_next = '0;
                        free_next  = '0;
                        if ({2'b00, base_next} < ADDR_LIMIT)
                        begin
                            room = ADDR_LIMIT - {2'b00, base_next};
                            clen = ({2'b00, hsize_next} > room) ? room
                                                                : {2'b00, hsize_next};
                            if (clen != '0)
                            begin
                                count_next = CW'(1);
                                free_next  = clen[31:0];
                                mem_we     = 1'b1;
                                mem_wa     = '0;
                                mem_wd     = '{start: base_next, len: clen[31:0]};
                            end
                        end
                    end
                end
                else if (start)
                begin
                    kind_next  = req.req_type;
                    a_next     = req.request_address;
                    size_next  = req.request_size;
                    rsz        = {1'b0, req.request_size} + 33'd7;
                    rsize_next = rsz & ~33'd7;
                    ar_next    = {2'b00, req.request_address} + {1'b0, rsize_next};
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                st_next    = ST_OK;
                addr_next  = '0;
                wen_next   = 1'b0;
                op_next    = OP_NONE;
                nfree_next = free_reg;
                iss_next   = '0;
                found_next = 1'b0;
                prv_next   = 1'b0;
                nxv_next   = 1'b0;
                fidx_next  = count_reg;
                state_next = S_SCAN;
                if (size_reg == '0)
                begin
                    st_next    = ST_ZERO;
                    state_next = S_FIN;
                end
                else if (kind_reg == KIND_FREE)
                begin
                    if (a_reg == '0 || ar_reg > ADDR_LIMIT
                        || ({1'b0, free_reg} + rsize_reg) > 33'h0_FFFF_FFFF)
                    begin
                        st_next    = ST_IGNORED;
                        state_next = S_FIN;
                    end
                end
                else if (size_reg > free_reg)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_FIN;
                end
                else if (kind_reg == KIND_AT && a_reg == '0)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_FIN;
                end
            end

            S_SCAN:
            begin
                issue = iss_reg < count_reg;
                if (dv_reg)
                begin
                    e_end = {1'b0, rd.start} + {1'b0, rd.len};
                    case (kind_reg) inside
                        KIND_FIRST, KIND_HIGHEST:
                        begin
                            hit  = {1'b0, rd.len} >= rsize_reg;
                            stop = hit && (kind_reg == KIND_FIRST);
                        end
                        KIND_AT:
                        begin
                            hit  = (rd.start <= a_reg) && (ar_reg <= {1'b0, e_end});
                            stop = hit;
                        end
                        default:
                        begin
                            if (rd.start <= a_reg)
                            begin
                                prv_next  = 1'b1;
                                prev_next = rd;
                            end
                            else
                            begin
                                nxv_next  = 1'b1;
                                nxt_next  = rd;
                                fidx_next = CW'(didx_reg);
                                stop      = 1'b1;
                            end
                        end
                    endcase
                    if (hit)
                    begin
                        found_next = 1'b1;
                        pick_next  = didx_reg;
                        pe_next    = rd;
                    end
                end
                if (stop || (!dv_reg && !issue))
                begin
                    state_next = S_DECIDE;
                end
                else if (issue)
                begin
                    iss_next  = iss_reg + CW'(1);
                    dv_next   = 1'b1;
                    didx_next = iss_reg[IW-1:0];
                end
            end

            S_DECIDE:
            begin
                state_next = S_WRITE;
                case (kind_reg) inside
                    KIND_FIRST, KIND_HIGHEST:
                    begin
                        if (!found_reg)
                        begin
                            st_next = ST_NOFIT;
                        end
                        else
                        begin
                            nfree_next = free_reg - rsize_reg[31:0];
                            len1       = pe_reg.len - rsize_reg[31:0];
                            if ({1'b0, pe_reg.len} == rsize_reg)
                            begin
                                addr_next = pe_reg.start;
                                op_next   = OP_REM;
                                opi_next  = CW'(pick_reg);
                            end
                            else if (kind_reg == KIND_FIRST)
                            begin
                                addr_next = pe_reg.start;
                                wen_next  = 1'b1;
                                widx_next = pick_reg;
                                wd_next   = '{start: pe_reg.start + rsize_reg[31:0],
                                              len: len1};
                            end
                            else
                            begin
                                addr_next = pe_reg.start + len1;
                                wen_next  = 1'b1;
                                widx_next = pick_reg;
                                wd_next   = '{start: pe_reg.start, len: len1};
                            end
                        end
                    end
                    KIND_AT:
                    begin
                        e_end = {1'b0, pe_reg.start} + {1'b0, pe_reg.len};
                        head  = pe_reg.start < a_reg;
                        tail  = ar_reg < {1'b0, e_end};
                        if (!found_reg)
                        begin
                            st_next = ST_NOFIT;
                        end
                        else if (head && tail && count_reg >= MAXC)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            addr_next  = a_reg;
                            nfree_next = free_reg - rsize_reg[31:0];
                            widx_next  = pick_reg;
                            if (head)
                            begin
                                wen_next = 1'b1;
                                wd_next  = '{start: pe_reg.start,
                                             len: a_reg - pe_reg.start};
                                if (tail)
                                begin
                                    op_next  = OP_INS;
                                    opi_next = CW'(pick_reg) + CW'(1);
                                    ins_next = '{start: ar_reg[31:0],
                                                 len: e_end[31:0] - ar_reg[31:0]};
                                end
                            end
                            else if (tail)
                            begin
                                wen_next = 1'b1;
                                wd_next  = '{start: ar_reg[31:0],
                                             len: e_end[31:0] - ar_reg[31:0]};
                            end
                            else
                            begin
                                op_next  = OP_REM;
                                opi_next = CW'(pick_reg);
                            end
                        end
                    end
                    default:
                    begin
                        ptop  = {1'b0, prev_reg.start} + {1'b0, prev_reg.len};
                        ign   = (nxv_reg && {2'b00, nxt_reg.start} < ar_reg)
                                || (prv_reg && ptop > {1'b0, a_reg});
                        mnext = nxv_reg && {2'b00, nxt_reg.start} == ar_reg;
                        mprev = prv_reg && ptop == {1'b0, a_reg};
                        if (ign)
                        begin
                            st_next = ST_IGNORED;
                        end
                        else if (!mprev && !mnext && count_reg >= MAXC)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            nfree_next = free_reg + rsize_reg[31:0];
                            if (mprev)
                            begin
                                wen_next  = 1'b1;
                                widx_next = IW'(fidx_reg - CW'(1));
                                if (mnext)
                                begin
                                    wd_next  = '{start: prev_reg.start,
                                                 len: prev_reg.len + rsize_reg[31:0]
                                                      + nxt_reg.len};
                                    op_next  = OP_REM;
                                    opi_next = fidx_reg;
                                end
                                else
                                begin
                                    wd_next = '{start: prev_reg.start,
                                                len: prev_reg.len + rsize_reg[31:0]};
                                end
                            end
                            else if (mnext)
                            begin
                                wen_next  = 1'b1;
                                widx_next = IW'(fidx_reg);
                                wd_next   = '{start: a_reg,
                                              len: nxt_reg.len + rsize_reg[31:0]};
                            end
                            else
                            begin
                                op_next  = OP_INS;
                                opi_next = fidx_reg;
                                ins_next = '{start: a_reg, len: rsize_reg[31:0]};
                            end
                        end
                    end
                endcase
            end

            S_WRITE:
            begin
                mem_we = wen_reg;
                mem_wa = widx_reg;
                mem_wd = wd_reg;
                sh_next = (op_reg == OP_REM) ? opi_reg + CW'(1) : count_reg;
                state_next = (op_reg == OP_NONE) ? S_FIN : S_SHIFT;
            end

            S_SHIFT:
            begin
                mem_we = shv_reg;
                mem_wa = shwa_reg;
                mem_wd = rd;
                if (op_reg == OP_REM)
                begin
                    issue     = sh_reg < count_reg;
                    mem_ra    = sh_reg[IW-1:0];
                    shwa_next = IW'(sh_reg - CW'(1));
                    if (issue)
                    begin
                        sh_next = sh_reg + CW'(1);
                    end
                end
                else
                begin
                    issue     = sh_reg > opi_reg;
                    mem_ra    = IW'(sh_reg - CW'(1));
                    shwa_next = IW'(sh_reg);
                    if (issue)
                    begin
                        sh_next = sh_reg - CW'(1);
                    end
                end
                shv_next = issue;
                if (!issue && !shv_reg)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (op_reg == OP_INS)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = IW'(opi_reg);
                    mem_wd     = ins_reg;
                    count_next = count_reg + CW'(1);
                end
                else if (op_reg == OP_REM)
                begin
                    count_next = count_reg - CW'(1);
                end
                free_next  = nfree_reg;
                done_next  = 1'b1;
                rsp_next   = '{block_address: (st_reg == ST_OK) ? addr_reg : 32'd0,
                               status: st_reg, free_bytes: nfree_reg};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            hsize_reg <= '0;
            count_reg <= '0;
            free_reg  <= '0;
            dv_reg    <= 1'b0;
            shv_reg   <= 1'b0;
            done_reg  <= 1'b0;
            op_reg    <= OP_NONE;
            wen_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            hsize_reg <= hsize_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            dv_reg    <= dv_next;
            shv_reg   <= shv_next;
            done_reg  <= done_next;
            op_reg    <= op_next;
            wen_reg   <= wen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        a_reg     <= a_next;
        size_reg  <= size_next;
        rsize_reg <= rsize_next;
        ar_reg    <= ar_next;
        iss_reg   <= iss_next;
        didx_reg  <= didx_next;
        found_reg <= found_next;
        pick_reg  <= pick_next;
        pe_reg    <= pe_next;
        prv_reg   <= prv_next;
        nxv_reg   <= nxv_next;
        prev_reg  <= prev_next;
        nxt_reg   <= nxt_next;
        fidx_reg  <= fidx_next;
        st_reg    <= st_next;
        addr_reg  <= addr_next;
        widx_reg  <= widx_next;
        wd_reg    <= wd_next;
        opi_reg   <= opi_next;
        ins_reg   <= ins_next;
        nfree_reg <= nfree_next;
        sh_reg    <= sh_next;
        shwa_reg  <= shwa_next;
        rsp_reg   <= rsp_next;
    end

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the first-fit extent allocator core
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffea_pkg::*;

    localparam int NUM_EXTENTS = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    first_fit_extent_allocator_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [31:0] heap_base_q;
    logic [31:0] heap_size_q;
    logic [31:0] ext_start [NUM_EXTENTS];
    logic [31:0] ext_len [NUM_EXTENTS];
    int unsigned ext_count;
    logic [31:0] free_count;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int unsigned error_count;
    int unsigned accepted_count;
    int unsigned result_count;
    int unsigned ok_count;
    int unsigned idle_cycles;
    int unsigned gap_left;
    bit stim_done;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void rebuild_table();
        longint unsigned span;
        ext_count = 0;
        free_count = '0;
        span = heap_size_q;
        if (64'h1_0000_0000 - heap_base_q < span)
            span = 64'h1_0000_0000 - heap_base_q;
        if (span == 0)
            return;
        ext_start[0] = heap_base_q;
        ext_len[0] = span[31:0];
        ext_count = 1;
        free_count = span[31:0];
    endfunction

    function automatic void drop_extent(int unsigned i);
        for (int unsigned k = i; k + 1 < ext_count; k++)
        begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        if (ext_count > 0)
            ext_count--;
    endfunction

    function automatic void add_extent(int unsigned i, logic [31:0] s, logic [31:0] l);
        for (int unsigned k = ext_count; k > i; k--)
        begin
            ext_start[k] = ext_start[k - 1];
            ext_len[k] = ext_len[k - 1];
        end
        ext_start[i] = s;
        ext_len[i] = l;
        ext_count++;
    endfunction

    function automatic logic [2:0] carve_fit(bit highest, longint unsigned rsize,
                                             output logic [31:0] addr);
        int unsigned pick;
        bit found;
        pick = 0;
        found = 0;
        addr = '0;
        for (int unsigned i = 0; i < ext_count; i++)
        begin
            if (ext_len[i] >= rsize && !(found && !highest))
            begin
                pick = i;
                found = 1;
            end
        end
        if (!found)
            return ST_NOFIT;
        free_count = free_count - rsize[31:0];
        if (ext_len[pick] == rsize)
        begin
            addr = ext_start[pick];
            drop_extent(pick);
        end
        else if (highest)
        begin
            ext_len[pick] = ext_len[pick] - rsize[31:0];
            addr = ext_start[pick] + ext_len[pick];
        end
        else
        begin
            addr = ext_start[pick];
            ext_start[pick] = ext_start[pick] + rsize[31:0];
            ext_len[pick] = ext_len[pick] - rsize[31:0];
        end
        return ST_OK;
    endfunction

    function automatic logic [2:0] carve_at(longint unsigned a, longint unsigned rsize);
        longint unsigned s;
        longint unsigned e;
        for (int unsigned i = 0; i < ext_count; i++)
        begin
            s = ext_start[i];
            e = s + ext_len[i];
            if (s <= a && a + rsize <= e)
            begin
                if (s < a && a + rsize < e)
                begin
                    if (ext_count >= NUM_EXTENTS)
                        return ST_FULL;
                    ext_len[i] = 32'(a - s);
                    add_extent(i + 1, 32'(a + rsize), 32'(e - a - rsize));
                end
                else if (s < a)
                    ext_len[i] = 32'(a - s);
                else if (a + rsize < e)
                begin
                    ext_start[i] = 32'(a + rsize);
                    ext_len[i] = 32'(e - a - rsize);
                end
                else
                    drop_extent(i);
                free_count = free_count - rsize[31:0];
                return ST_OK;
            end
        end
        return ST_NOFIT;
    endfunction

    function automatic logic [2:0] release_block(longint unsigned a, longint unsigned rsize);
        int unsigned idx;
        longint unsigned blk_end;
        longint unsigned ptop;
        bit join_prev;
        bit join_next;
        idx = 0;
        join_prev = 0;
        join_next = 0;
        blk_end = a + rsize;
        if (a == 0 || blk_end > 64'h1_0000_0000 || free_count + rsize > 64'hFFFF_FFFF)
            return ST_IGNORED;
        while (idx < ext_count && ext_start[idx] <= a)
            idx++;
        if (idx < ext_count)
        begin
            if (ext_start[idx] < blk_end)
                return ST_IGNORED;
            join_next = (ext_start[idx] == blk_end);
        end
        if (idx > 0)
        begin
            ptop = longint'(ext_start[idx - 1]) + ext_len[idx - 1];
            if (ptop > a)
                return ST_IGNORED;
            join_prev = (ptop == a);
        end
        if (join_prev && join_next)
        begin
            ext_len[idx - 1] = ext_len[idx - 1] + rsize[31:0] + ext_len[idx];
            drop_extent(idx);
        end
        else if (join_prev)
            ext_len[idx - 1] = ext_len[idx - 1] + rsize[31:0];
        else if (join_next)
        begin
            ext_start[idx] = a[31:0];
            ext_len[idx] = ext_len[idx] + rsize[31:0];
        end
        else
        begin
            if (ext_count >= NUM_EXTENTS)
                return ST_FULL;
            add_extent(idx, a[31:0], rsize[31:0]);
        end
        free_count = free_count + rsize[31:0];
        return ST_OK;
    endfunction

    function automatic rsp_t serve_request(req_t r);
        rsp_t o;
        longint unsigned rsize;
        logic [31:0] addr;
        o = '0;
        addr = '0;
        rsize = (longint'(r.request_size) + 7) & ~64'd7;
        if (r.request_size == 0)
            o.status = ST_ZERO;
        else if (r.req_type == KIND_FREE)
            o.status = release_block(r.request_address, rsize);
        else if (r.request_size > free_count)
            o.status = ST_NOFIT;
        else if (r.req_type == KIND_AT)
        begin
            if (r.request_address == 0)
                o.status = ST_NOFIT;
            else
            begin
                o.status = carve_at(r.request_address, rsize);
                if (o.status == ST_OK)
                    addr = r.request_address;
            end
        end
        else
            o.status = carve_fit(r.req_type == KIND_HIGHEST, rsize, addr);
        o.block_address = addr;
        o.free_bytes = free_count;
        return o;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsps.push_back(serve_request(req));
                accepted_count <= accepted_count + 1;
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                start <= 1'b1;
                req <= pending_reqs.pop_front();
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h st=%0d free=%h", $time,
                         rsp.block_address, rsp.status, rsp.free_bytes);
                error_count++;
            end
            else
            begin
                automatic rsp_t e = expected_rsps.pop_front();
                result_count++;
                if (e.status == ST_OK)
                    ok_count++;
                if (e.block_address !== rsp.block_address)
                begin
                    $display("%0t: block_address expected %h actual %h", $time,
                             e.block_address, rsp.block_address);
                    error_count++;
                end
                if (e.status !== rsp.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, rsp.status);
                    error_count++;
                end
                if (e.free_bytes !== rsp.free_bytes)
                begin
                    $display("%0t: free_bytes expected %h actual %h", $time,
                             e.free_bytes, rsp.free_bytes);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_HEAP_BASE)
            heap_base_q = data;
        else
            heap_size_q = data;
        rebuild_table();
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || busy || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic queue_req(logic [1:0] kind, logic [31:0] a, logic [31:0] s);
        req_t r;
        r.req_type = kind;
        r.request_address = a;
        r.request_size = s;
        pending_reqs.push_back(r);
    endtask

    // mostly well-formed traffic inside the heap, some noise
    task automatic queue_random(int unsigned n, logic [31:0] base, logic [31:0] span);
        logic [31:0] a;
        logic [31:0] s;
        int unsigned sel;
        for (int unsigned i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 19);
            s = (sel == 0) ? $urandom() : $urandom_range(0, 200);
            if (sel == 1)
                s = 0;
            a = base + ($urandom_range(0, span / 8) * 8);
            if (sel == 2)
                a = $urandom();
            if (sel == 3)
                a = 0;
            queue_req(2'($urandom_range(0, 3)), a, s);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        accepted_count = 0;
        result_count = 0;
        ok_count = 0;
        idle_cycles = 0;
        heap_base_q = '0;
        heap_size_q = '0;
        rebuild_table();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty heap after reset
        queue_req(KIND_FIRST, 32'h0, 32'h8);
        queue_req(KIND_FREE, 32'h1000, 32'h10);
        wait_drained();

        write_reg(REG_HEAP_BASE, 32'h1000);
        write_reg(REG_HEAP_SIZE, 32'h400);
        queue_req(KIND_FIRST, 32'h0, 32'h0);
        queue_req(KIND_FIRST, 32'h0, 32'h1);
        queue_req(KIND_HIGHEST, 32'hFFFF_FFFF, 32'h11);
        queue_req(KIND_AT, 32'h1100, 32'h20);
        queue_req(KIND_AT, 32'h0, 32'h8);
        queue_req(KIND_AT, 32'h1100, 32'h8);
        queue_req(KIND_FIRST, 32'h0, 32'hFFFF_FFFF);
        queue_req(KIND_FREE, 32'h0, 32'h8);
        queue_req(KIND_FREE, 32'h1100, 32'h20);
        queue_req(KIND_FREE, 32'h1100, 32'h20);
        queue_req(KIND_FREE, 32'h1000, 32'h8);
        queue_req(KIND_FREE, 32'hFFFF_FFF8, 32'h10);
        queue_req(KIND_FREE, 32'h8000, 32'hFFFF_FFFF);
        queue_req(KIND_AT, 32'h1003, 32'h5);
        queue_req(KIND_FREE, 32'h1003, 32'h8);
        queue_req(KIND_HIGHEST, 32'h0, 32'h3F8);
        wait_drained();

        // fill the table with fragments to reach the full case
        write_reg(REG_HEAP_BASE, 32'h2000);
        for (int unsigned i = 0; i < 40; i++)
            queue_req(KIND_AT, 32'h2008 + i * 16, 32'h8);
        wait_drained();
        for (int unsigned i = 0; i < 40; i++)
            queue_req(KIND_FREE, 32'h2008 + i * 16, 32'h8);
        wait_drained();

        // heap clipped at the top of the address space
        write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
        write_reg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
        queue_req(KIND_HIGHEST, 32'h0, 32'h10);
        queue_req(KIND_FREE, 32'hFFFF_FFF0, 32'h10);
        queue_req(KIND_AT, 32'hFFFF_FFF8, 32'h8);
        queue_req(KIND_FREE, 32'hFFFF_FFF8, 32'h9);
        wait_drained();

        // heap of 0xFFFF_FFFF bytes from address 0
        write_reg(REG_HEAP_BASE, 32'h0);
        queue_random(150, 32'h0, 32'h400);
        wait_drained();

        write_reg(REG_HEAP_BASE, 32'h4000_0000);
        write_reg(REG_HEAP_SIZE, 32'h800);
        queue_random(600, 32'h4000_0000, 32'h800);
        wait_drained();

        write_reg(REG_HEAP_SIZE, 32'h200);
        queue_random(500, 32'h4000_0000, 32'h200);
        wait_drained();

        write_reg(REG_HEAP_BASE, $urandom() & ~32'h7);
        write_reg(REG_HEAP_SIZE, 32'h1000);
        queue_random(550, heap_base_q, 32'h1000);
        wait_drained();

        $display("ran %0d requests over several heap settings, %0d results checked, %0d ok",
                 accepted_count, result_count, ok_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/ffea_pkg.sv
sv/ffea_ext_mem.sv
sv/first_fit_extent_allocator_core.sv
tb/tb.sv
